// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the HSV range mask.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/core/hsvm_pkg.sv -----
// Types, constants and helper functions of the HSV range mask.
package hsvm_pkg;

  localparam int FIX_SHIFT = 12;
  localparam int DIV_BITS = 20;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
  localparam int LATENCY = DIV_STAGES + 4;

  localparam logic [DIV_BITS-1:0] SAT_NUM = DIV_BITS'(255 << FIX_SHIFT);
  localparam logic [DIV_BITS-1:0] HUE_NUM = DIV_BITS'(30 << FIX_SHIFT);
  localparam int RCP_HUE_W = 17;
  localparam logic [28:0] FIX_HALF_U = 29'd2048;
  localparam logic signed [30:0] FIX_HALF_S = 31'sd2048;
  localparam logic signed [18:0] HUE_WRAP = 19'sd180;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_HUE_LOW  = 3'd1,
    REG_HUE_HIGH = 3'd2,
    REG_SAT_LOW  = 3'd3,
    REG_SAT_HIGH = 3'd4,
    REG_VAL_LOW  = 3'd5,
    REG_VAL_HIGH = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic       in_range;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } result_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         v;
    logic [7:0]         diff;
    logic signed [11:0] sector;
  } prep_t;

  typedef struct packed {
    logic [7:0]          rem;
    logic [DIV_BITS-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    prep_t                 prep;
    logic [DIV_BITS-1:0]   rcp_sat;
    logic [RCP_HUE_W-1:0]  rcp_hue;
  } recip_t;

  function automatic div_lane_t div_step(div_lane_t lane, logic [7:0] d, logic nbit);
    logic [8:0] t;
    div_lane_t  res;
    t = {lane.rem, nbit};
    if (t >= {1'b0, d}) begin
      res.rem = 8'(t - {1'b0, d});
      res.quo = {lane.quo[DIV_BITS-2:0], 1'b1};
    end else begin
      res.rem = t[7:0];
      res.quo = {lane.quo[DIV_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [DIV_BITS-1:0] round_q(div_lane_t lane, logic [7:0] d);
    logic [8:0] twice;
    logic       inc;
    twice = {lane.rem, 1'b0};
    inc = (twice > {1'b0, d}) || ((twice == {1'b0, d}) && lane.quo[0]);
    if (d == 8'd0) begin
      return '0;
    end
    return lane.quo + DIV_BITS'(inc);
  endfunction

endpackage

// ----- rtl/core/hsvm_prep.sv -----
// Input stage: channel maximum, minimum, difference and hue sector term.
module hsvm_prep import hsvm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  pixel_t pixel,
  output logic   out_valid,
  output prep_t  out
);

  logic [7:0]         mx;
  logic [7:0]         mn;
  logic [7:0]         diff;
  logic signed [11:0] sector;
  logic signed [11:0] b;
  logic signed [11:0] g;
  logic signed [11:0] r;
  logic signed [11:0] d;

  always_comb begin
    mx = pixel.blue;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.red > mx) mx = pixel.red;
    mn = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.red < mn) mn = pixel.red;
    diff = mx - mn;
    b = $signed({4'd0, pixel.blue});
    g = $signed({4'd0, pixel.green});
    r = $signed({4'd0, pixel.red});
    d = $signed({4'd0, diff});
    if (mx == pixel.red) begin
      sector = g - b;
    end else if (mx == pixel.green) begin
      sector = b - r + (d <<< 1);
    end else begin
      sector = r - g + (d <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out.v      <= mx;
    out.diff   <= diff;
    out.sector <= sector;
  end

endmodule

// ----- rtl/core/hsvm_recip.sv -----
// Pipelined restoring dividers for the saturation and hue reciprocals.
module hsvm_recip import hsvm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  prep_t  in_data,
  output logic   out_valid,
  output recip_t out
);

  logic      vld   [1:DIV_STAGES];
  prep_t     data  [1:DIV_STAGES];
  div_lane_t sat_l [1:DIV_STAGES];
  div_lane_t hue_l [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic      cur_v;
    prep_t     cur;
    div_lane_t cur_sat;
    div_lane_t cur_hue;
    div_lane_t sat_next;
    div_lane_t hue_next;

    if (k == 0) begin : g_first
      assign cur_v   = in_valid;
      assign cur     = in_data;
      assign cur_sat = '0;
      assign cur_hue = '0;
    end else begin : g_inner
      assign cur_v   = vld[k];
      assign cur     = data[k];
      assign cur_sat = sat_l[k];
      assign cur_hue = hue_l[k];
    end

    always_comb begin
      sat_next = cur_sat;
      hue_next = cur_hue;
      for (int i = 0; i < DIV_STEPS; i++) begin
        sat_next = div_step(sat_next, cur.v, SAT_NUM[DIV_BITS-1-(k*DIV_STEPS+i)]);
        hue_next = div_step(hue_next, cur.diff, HUE_NUM[DIV_BITS-1-(k*DIV_STEPS+i)]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= cur_v;
      end
      data[k+1]  <= cur;
      sat_l[k+1] <= sat_next;
      hue_l[k+1] <= hue_next;
    end
  end

  logic [DIV_BITS-1:0] hue_round;

  assign hue_round = round_q(hue_l[DIV_STAGES], data[DIV_STAGES].diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[DIV_STAGES];
    end
    out.prep    <= data[DIV_STAGES];
    out.rcp_sat <= round_q(sat_l[DIV_STAGES], data[DIV_STAGES].v);
    out.rcp_hue <= hue_round[RCP_HUE_W-1:0];
  end

endmodule

// ----- rtl/core/hsvm_classify.sv -----
// Reciprocal products, fixed-point rounding, hue wrap and range test.
`include "assert_macros.svh"

module hsvm_classify import hsvm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  recip_t  in_data,
  output logic    done,
  output result_t result
);

  logic               mul_valid;
  logic [27:0]        sprod;
  logic signed [29:0] hprod;
  logic [7:0]         mul_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= in_valid;
    end
    sprod <= in_data.prep.diff * in_data.rcp_sat;
    hprod <= in_data.prep.sector * $signed({1'b0, in_data.rcp_hue});
    mul_v <= in_data.prep.v;
  end

  logic [28:0]        ssum;
  logic signed [30:0] hsum;
  logic signed [18:0] hq;
  logic signed [18:0] hw;
  logic [7:0]         hue;
  logic [7:0]         sat;
  logic               hue_ok;
  logic               hit;

  always_comb begin
    ssum = {1'b0, sprod} + FIX_HALF_U;
    sat  = ssum[19:12];
    hsum = $signed({hprod[29], hprod}) + FIX_HALF_S;
    hq   = $signed(hsum[30:12]);
    hw   = hq[18] ? hq + HUE_WRAP : hq;
    hue  = hw[7:0];
    if (cfg.hue_low <= cfg.hue_high) begin
      hue_ok = (hue >= cfg.hue_low) && (hue <= cfg.hue_high);
    end else begin
      hue_ok = (hue >= cfg.hue_low) || (hue <= cfg.hue_high);
    end
    hit = cfg.enable && hue_ok &&
          (sat >= cfg.sat_low) && (sat <= cfg.sat_high) &&
          (mul_v >= cfg.val_low) && (mul_v <= cfg.val_high);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_valid;
    end
    result.in_range   <= hit;
    result.hue        <= hue;
    result.saturation <= sat;
    result.brightness <= mul_v;
  end

  `ASSERT_AT(a_hue_span, clk, rst, done |-> (result.hue <= 8'd179))
  `ASSERT_AT(a_mask_gated, clk, rst, (done && result.in_range) |-> cfg.enable)
  `ASSERT_AT(a_black_pixel, clk, rst,
    (done && (result.brightness == 8'd0)) |-> ((result.saturation == 8'd0) && (result.hue == 8'd0)))

endmodule

// ----- rtl/core/hsv_range_pixel_mask.sv -----
// Top level of the HSV range mask: register file and pixel pipeline.
//
// Takes one BGR pixel per clock whenever start is high; busy never rises, so a
// new pixel may enter in every cycle. Each pixel comes out on result, marked
// by a one-cycle done strobe, in input order. Its path runs through the input
// stage, the two 20-bit reciprocal dividers, four quotient bits per stage over
// five stages, and then the rounding, multiply and output stages. There is no
// output backpressure: results must be taken when shown. Registers are written
// through the cfg channel, which is always ready; write them only while no
// pixel is in flight. Index 7 is ignored.
`include "assert_macros.svh"

module hsv_range_pixel_mask import hsvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  pixel_t     pixel,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b0;
      cfg.hue_low  <= 8'd0;
      cfg.hue_high <= 8'd255;
      cfg.sat_low  <= 8'd0;
      cfg.sat_high <= 8'd255;
      cfg.val_low  <= 8'd0;
      cfg.val_high <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE:   cfg.enable   <= cfg_data[0];
        REG_HUE_LOW:  cfg.hue_low  <= cfg_data;
        REG_HUE_HIGH: cfg.hue_high <= cfg_data;
        REG_SAT_LOW:  cfg.sat_low  <= cfg_data;
        REG_SAT_HIGH: cfg.sat_high <= cfg_data;
        REG_VAL_LOW:  cfg.val_low  <= cfg_data;
        REG_VAL_HIGH: cfg.val_high <= cfg_data;
        default: ;
      endcase
    end
  end

  logic   prep_valid;
  prep_t  prep;
  logic   rcp_valid;
  recip_t rcp;

  hsvm_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixel     (pixel),
    .out_valid (prep_valid),
    .out       (prep)
  );

  hsvm_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_data   (prep),
    .out_valid (rcp_valid),
    .out       (rcp)
  );

  hsvm_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (rcp_valid),
    .in_data  (rcp),
    .done     (done),
    .result   (result)
  );

  `ASSERT_AT(a_latency, clk, rst, (start && !busy) |-> ##LATENCY done)
  `ASSERT_AT(a_no_orphan, clk, rst, done |-> $past(start && !busy, LATENCY))
  `ASSERT_NEVER(a_never_busy, clk, rst, busy)

endmodule
